@@ sv/srs_pkg.sv @@
package srs_pkg;

  localparam int SEQ_W            = 3;
  localparam int WIN_W            = 3;
  localparam int DEF_MAX_WINDOW   = 4;
  localparam int DEF_PAYLOAD_BITS = 64;
  localparam int ADDR_W           = 2;
  localparam int DATA_W           = 32;

  localparam logic [ADDR_W-1:0] ADDR_WINDOW  = 2'd0;
  localparam logic [WIN_W-1:0]  WINDOW_RESET = 3'd4;

  typedef enum logic [1:0] {
    REQ_SEND    = 2'd0,
    REQ_ACK     = 2'd1,
    REQ_TIMEOUT = 2'd2,
    REQ_NONE    = 2'd3
  } req_type_e;

  // shared control seen by every cell of the row
  typedef struct packed {
    logic [SEQ_W-1:0] key;
    logic             remove;
    logic             append;
    logic [SEQ_W-1:0] new_seq;
  } srs_cell_ctrl_t;

  // distance from b forward to a, modulo the sequence space
  function automatic logic [SEQ_W-1:0] seq_dist(input logic [SEQ_W-1:0] a,
                                                input logic [SEQ_W-1:0] b);
    seq_dist = SEQ_W'(a - b);
  endfunction

endpackage

@@ sv/srs_req_if.sv @@
interface srs_req_if import srs_pkg::*; #(
  parameter int PAYLOAD_BITS = DEF_PAYLOAD_BITS
);
  logic                    valid;
  logic                    ready;
  logic [1:0]              req_type;
  logic [PAYLOAD_BITS-1:0] payload;
  logic [SEQ_W-1:0]        ack_number;
  logic                    ack_checksum_ok;
  logic [SEQ_W-1:0]        expired_seq;

  modport source (output valid, req_type, payload, ack_number, ack_checksum_ok, expired_seq,
                  input ready);
  modport sink (input valid, req_type, payload, ack_number, ack_checksum_ok, expired_seq,
                output ready);
endinterface

@@ sv/srs_res_if.sv @@
interface srs_res_if import srs_pkg::*; #(
  parameter int PAYLOAD_BITS = DEF_PAYLOAD_BITS
);
  logic                    valid;
  logic                    ready;
  logic                    accepted;
  logic                    transmit;
  logic [SEQ_W-1:0]        tx_seq;
  logic [PAYLOAD_BITS-1:0] tx_payload;
  logic                    timer_start;
  logic                    timer_stop;
  logic [SEQ_W-1:0]        timer_seq;
  logic                    ack_matched;
  logic                    window_full;

  modport source (output valid, accepted, transmit, tx_seq, tx_payload, timer_start,
                  timer_stop, timer_seq, ack_matched, window_full,
                  input ready);
  modport sink (input valid, accepted, transmit, tx_seq, tx_payload, timer_start,
                timer_stop, timer_seq, ack_matched, window_full,
                output ready);
endinterface

@@ sv/srs_cell.sv @@
module srs_cell import srs_pkg::*; #(
  parameter int PAYLOAD_BITS = DEF_PAYLOAD_BITS
) (
  input  logic                    clk_i,
  input  srs_cell_ctrl_t          ctrl_i,
  input  logic                    occ_i,
  input  logic                    tail_i,
  input  logic [PAYLOAD_BITS-1:0] new_data_i,
  input  logic                    found_i,
  input  logic [PAYLOAD_BITS-1:0] sel_data_i,
  input  logic [SEQ_W-1:0]        nb_seq_i,
  input  logic [PAYLOAD_BITS-1:0] nb_data_i,
  output logic                    found_o,
  output logic [PAYLOAD_BITS-1:0] sel_data_o,
  output logic [SEQ_W-1:0]        seq_o,
  output logic [PAYLOAD_BITS-1:0] data_o
);

  logic [SEQ_W-1:0]        seq_q, seq_d;
  logic [PAYLOAD_BITS-1:0] data_q, data_d;
  logic                    hit;

  // first occupied cell holding the key wins
  assign hit        = occ_i && (seq_q == ctrl_i.key) && !found_i;
  assign found_o    = found_i || hit;
  assign sel_data_o = hit ? data_q : sel_data_i;
  assign seq_o      = seq_q;
  assign data_o     = data_q;

  always_comb begin
    seq_d  = seq_q;
    data_d = data_q;
    if (ctrl_i.remove && found_o) begin
      // close the gap: take the neighbor's entry
      seq_d  = nb_seq_i;
      data_d = nb_data_i;
    end else if (ctrl_i.append && tail_i) begin
      seq_d  = ctrl_i.new_seq;
      data_d = new_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    seq_q  <= seq_d;
    data_q <= data_d;
  end

endmodule

@@ sv/selective_repeat_sender_window.sv @@
// Sender window of a selective-repeat ARQ link. Each request item (send, ack arrived, timer
// expired) gives exactly one result item: send accepted or refused, a packet to transmit or
// retransmit, a timer start/stop command, ack match and the window-full flag. Outstanding
// packets live in a row of MAX_WINDOW cells, oldest first; an ack removes its entry and the
// cells behind it shift forward by one. Window size is written over APB at address 0
// (0 acts as 1, values above MAX_WINDOW act as MAX_WINDOW); the user must do so only while
// no item is in flight; the block does not enforce this. A request is registered, then its
// key match ripples through the cell row to update it; until then, new requests wait.
module selective_repeat_sender_window import srs_pkg::*; #(
  parameter int MAX_WINDOW   = DEF_MAX_WINDOW,
  parameter int PAYLOAD_BITS = DEF_PAYLOAD_BITS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  srs_req_if.sink           req_i,
  srs_res_if.source         res_o
);

  localparam int CntW = $clog2(MAX_WINDOW + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(MAX_WINDOW);

  logic [WIN_W-1:0] window_q;
  logic [SEQ_W-1:0] next_seq_q, next_seq_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             full_q, full_d;
  logic             busy_q;
  logic             fire;

  req_type_e               req_type_q;
  logic [PAYLOAD_BITS-1:0] payload_q;
  logic [SEQ_W-1:0]        ack_q;
  logic                    ack_ok_q;
  logic [SEQ_W-1:0]        exp_q;

  logic                    out_valid_q;
  logic                    accepted_q, accepted_d;
  logic                    transmit_q, transmit_d;
  logic [SEQ_W-1:0]        tx_seq_q, tx_seq_d;
  logic [PAYLOAD_BITS-1:0] tx_payload_q, tx_payload_d;
  logic                    timer_start_q, timer_start_d;
  logic                    timer_stop_q, timer_stop_d;
  logic [SEQ_W-1:0]        timer_seq_q, timer_seq_d;
  logic                    ack_matched_q, ack_matched_d;
  logic                    window_full_q, window_full_d;

  srs_cell_ctrl_t          ctrl;
  logic                    found [MAX_WINDOW+1];
  logic [PAYLOAD_BITS-1:0] sel   [MAX_WINDOW+1];
  logic [SEQ_W-1:0]        seqs  [MAX_WINDOW+1];
  logic [PAYLOAD_BITS-1:0] datas [MAX_WINDOW+1];

  logic [WIN_W-1:0] eff_win;
  logic [SEQ_W-1:0] head_after;
  logic [SEQ_W-1:0] seq_inc;
  logic             refusing;

  // configuration port
  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_WINDOW) ? DATA_W'(window_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= WINDOW_RESET;
    end else if (psel && penable && pwrite && paddr == ADDR_WINDOW) begin
      window_q <= pwdata[WIN_W-1:0];
    end
  end

  always_comb begin
    if (window_q == '0) begin
      eff_win = WIN_W'(1);
    end else if (int'(window_q) > MAX_WINDOW) begin
      eff_win = WIN_W'(MAX_WINDOW);
    end else begin
      eff_win = window_q;
    end
  end

  // request side
  assign req_i.ready = !busy_q;
  assign fire        = busy_q && (!out_valid_q || res_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (req_i.valid && req_i.ready) begin
      busy_q <= 1'b1;
    end else if (fire) begin
      busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      req_type_q <= req_type_e'(req_i.req_type);
      payload_q  <= req_i.payload;
      ack_q      <= req_i.ack_number;
      ack_ok_q   <= req_i.ack_checksum_ok;
      exp_q      <= req_i.expired_seq;
    end
  end

  // cell row
  assign found[0]              = 1'b0;
  assign sel[0]                = '0;
  assign seqs[MAX_WINDOW]      = '0;
  assign datas[MAX_WINDOW]     = '0;

  for (genvar g = 0; g < MAX_WINDOW; g++) begin : g_cell
    srs_cell #(
      .PAYLOAD_BITS(PAYLOAD_BITS)
    ) u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .occ_i      (CntW'(g) < count_q),
      .tail_i     (CntW'(g) == count_q),
      .new_data_i (payload_q),
      .found_i    (found[g]),
      .sel_data_i (sel[g]),
      .nb_seq_i   (seqs[g+1]),
      .nb_data_i  (datas[g+1]),
      .found_o    (found[g+1]),
      .sel_data_o (sel[g+1]),
      .seq_o      (seqs[g]),
      .data_o     (datas[g])
    );
  end

  assign refusing   = full_q || (count_q == CntMax);
  assign seq_inc    = SEQ_W'(next_seq_q + 1'b1);
  assign head_after = (count_q == '0) ? next_seq_q : seqs[0];

  always_comb begin
    next_seq_d    = next_seq_q;
    count_d       = count_q;
    full_d        = full_q;
    ctrl.key      = (req_type_q == REQ_ACK) ? ack_q : exp_q;
    ctrl.remove   = 1'b0;
    ctrl.append   = 1'b0;
    ctrl.new_seq  = next_seq_q;
    accepted_d    = 1'b0;
    transmit_d    = 1'b0;
    tx_seq_d      = '0;
    tx_payload_d  = '0;
    timer_start_d = 1'b0;
    timer_stop_d  = 1'b0;
    timer_seq_d   = '0;
    ack_matched_d = 1'b0;
    case (req_type_q)
      REQ_SEND: begin
        if (!refusing) begin
          ctrl.append   = fire;
          accepted_d    = 1'b1;
          transmit_d    = 1'b1;
          tx_seq_d      = next_seq_q;
          tx_payload_d  = payload_q;
          timer_start_d = 1'b1;
          timer_seq_d   = next_seq_q;
          next_seq_d    = seq_inc;
          count_d       = CntW'(count_q + 1'b1);
          if (seq_dist(seq_inc, head_after) >= eff_win) begin
            full_d = 1'b1;
          end
        end
      end
      REQ_ACK: begin
        if (ack_ok_q && count_q != '0 && seq_dist(ack_q, seqs[0]) < eff_win
            && found[MAX_WINDOW]) begin
          ctrl.remove   = fire;
          // oldest entry gone: window opens again
          if (found[1]) begin
            full_d = 1'b0;
          end
          count_d       = CntW'(count_q - 1'b1);
          timer_stop_d  = 1'b1;
          timer_seq_d   = ack_q;
          ack_matched_d = 1'b1;
        end
      end
      REQ_TIMEOUT: begin
        timer_start_d = 1'b1;
        timer_seq_d   = exp_q;
        if (found[MAX_WINDOW]) begin
          transmit_d   = 1'b1;
          tx_seq_d     = exp_q;
          tx_payload_d = sel[MAX_WINDOW];
        end
      end
      default: begin
      end
    endcase
    window_full_d = full_d || (count_d == CntMax);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_seq_q <= '0;
      count_q    <= '0;
      full_q     <= 1'b0;
    end else if (fire) begin
      next_seq_q <= next_seq_d;
      count_q    <= count_d;
      full_q     <= full_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      accepted_q    <= accepted_d;
      transmit_q    <= transmit_d;
      tx_seq_q      <= tx_seq_d;
      tx_payload_q  <= tx_payload_d;
      timer_start_q <= timer_start_d;
      timer_stop_q  <= timer_stop_d;
      timer_seq_q   <= timer_seq_d;
      ack_matched_q <= ack_matched_d;
      window_full_q <= window_full_d;
    end
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.accepted    = accepted_q;
  assign res_o.transmit    = transmit_q;
  assign res_o.tx_seq      = tx_seq_q;
  assign res_o.tx_payload  = tx_payload_q;
  assign res_o.timer_start = timer_start_q;
  assign res_o.timer_stop  = timer_stop_q;
  assign res_o.timer_seq   = timer_seq_q;
  assign res_o.ack_matched = ack_matched_q;
  assign res_o.window_full = window_full_q;

endmodule

@@ sv/srs_checker.sv @@
module srs_checker import srs_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             req_valid,
  input logic             req_ready,
  input logic             res_valid,
  input logic             res_ready,
  input logic             accepted,
  input logic             transmit,
  input logic             timer_start,
  input logic             timer_stop,
  input logic             ack_matched,
  input logic [SEQ_W-1:0] tx_seq,
  input logic [SEQ_W-1:0] timer_seq
);

  // one item at a time: ready drops in the cycle after a request is taken
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while previous item still in work");

  // a taken send always goes out and starts its own timer
  a_send_tx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && accepted |-> transmit && timer_start && !timer_stop && tx_seq == timer_seq)
    else $error("accepted send without transmit and timer start");

  // timer stop comes only with a matched ack
  a_stop_ack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> (timer_stop == ack_matched) && !(timer_stop && timer_start))
    else $error("timer stop and ack match disagree");

  // a stalled result holds
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !res_ready |=> res_valid && $stable(accepted) && $stable(tx_seq)
                               && $stable(timer_seq))
    else $error("result changed while stalled");

endmodule

bind selective_repeat_sender_window srs_checker u_srs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid   (req_i.valid),
  .req_ready   (req_i.ready),
  .res_valid   (res_o.valid),
  .res_ready   (res_o.ready),
  .accepted    (res_o.accepted),
  .transmit    (res_o.transmit),
  .timer_start (res_o.timer_start),
  .timer_stop  (res_o.timer_stop),
  .ack_matched (res_o.ack_matched),
  .tx_seq      (res_o.tx_seq),
  .timer_seq   (res_o.timer_seq)
);

@@ test/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import srs_pkg::*;

  localparam int PW          = DEF_PAYLOAD_BITS;
  localparam int MAXW        = DEF_MAX_WINDOW;
  localparam int CYCLE_LIMIT = 400000;
  localparam int MAX_SHOWN   = 10;
  localparam int N_PHASES    = 12;
  localparam int PHASE_LEN   = 120;

  localparam logic [PW-1:0] P_ONES = '1;
  localparam logic [PW-1:0] P_A5   = 64'hA5A5_A5A5_A5A5_A5A5;
  localparam logic [PW-1:0] P_5A   = 64'h5A5A_5A5A_5A5A_5A5A;

  localparam logic [WIN_W-1:0] WIN_PLAN [N_PHASES] =
    '{3'd1, 3'd0, 3'd7, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd1, 3'd2, 3'd7, 3'd4};

  typedef struct packed {
    req_type_e        kind;
    logic [PW-1:0]    payload;
    logic [SEQ_W-1:0] ack_num;
    logic             ack_ok;
    logic [SEQ_W-1:0] exp_seq;
  } win_req_t;

  typedef struct packed {
    logic             accepted;
    logic             transmit;
    logic [SEQ_W-1:0] tx_seq;
    logic [PW-1:0]    tx_payload;
    logic             timer_start;
    logic             timer_stop;
    logic [SEQ_W-1:0] timer_seq;
    logic             ack_matched;
    logic             window_full;
  } win_res_t;

  typedef struct {
    win_req_t req;
    bit       typed;
    win_res_t res;
  } dir_row_t;

  logic              clk_i;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  srs_req_if #(.PAYLOAD_BITS(PW)) req_bus ();
  srs_res_if #(.PAYLOAD_BITS(PW)) res_bus ();

  selective_repeat_sender_window #(
    .MAX_WINDOW  (MAXW),
    .PAYLOAD_BITS(PW)
  ) u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .req_i  (req_bus),
    .res_o  (res_bus)
  );

  // sender window mirror
  logic [WIN_W-1:0] win_reg;
  logic [SEQ_W-1:0] nxt_seq;
  logic [SEQ_W-1:0] out_seq [MAXW];
  logic [PW-1:0]    out_data [MAXW];
  int               out_cnt;
  bit               full;

  win_res_t tx_expect_q[$];
  dir_row_t dir_rows[$];

  bit idle_on;
  int rx_stall;
  int errors;
  int shown;
  int cycles;
  int n_items, n_results, n_taken, n_refused, n_matched, n_retx;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               tx_expect_q.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 24);
  endfunction

  function automatic bit send_blocked();
    return full || out_cnt >= MAXW;
  endfunction

  function automatic win_res_t mk_res(input int acc, input int tx,
                                      input int txs, input logic [PW-1:0] txp,
                                      input int tstart, input int tstop,
                                      input int tseq, input int matched,
                                      input int wfull);
    win_res_t o;
    o.accepted    = 1'(acc);
    o.transmit    = 1'(tx);
    o.tx_seq      = SEQ_W'(txs);
    o.tx_payload  = txp;
    o.timer_start = 1'(tstart);
    o.timer_stop  = 1'(tstop);
    o.timer_seq   = SEQ_W'(tseq);
    o.ack_matched = 1'(matched);
    o.window_full = 1'(wfull);
    return o;
  endfunction

  // advance the mirrored window by one request and return the result item
  function automatic win_res_t window_step(input win_req_t r);
    win_res_t         o;
    logic [WIN_W-1:0] eff;
    logic [SEQ_W-1:0] s;
    int               hit;
    o   = '0;
    eff = win_reg;
    if (eff < 1) eff = 1;
    if (eff > MAXW) eff = WIN_W'(MAXW);
    case (r.kind)
      REQ_SEND: begin
        if (!send_blocked()) begin
          s                 = nxt_seq;
          out_seq[out_cnt]  = s;
          out_data[out_cnt] = r.payload;
          out_cnt++;
          nxt_seq = s + 1'b1;
          if (WIN_W'(SEQ_W'(nxt_seq - out_seq[0])) >= eff) full = 1'b1;
          o.accepted    = 1'b1;
          o.transmit    = 1'b1;
          o.tx_seq      = s;
          o.tx_payload  = r.payload;
          o.timer_start = 1'b1;
          o.timer_seq   = s;
        end
      end
      REQ_ACK: begin
        if (r.ack_ok && out_cnt > 0 && WIN_W'(SEQ_W'(r.ack_num - out_seq[0])) < eff) begin
          hit = -1;
          for (int i = 0; i < out_cnt; i++)
            if (hit < 0 && out_seq[i] == r.ack_num) hit = i;
          if (hit >= 0) begin
            // removing the oldest entry reopens the window
            if (hit == 0) full = 1'b0;
            for (int k = hit; k + 1 < out_cnt; k++) begin
              out_seq[k]  = out_seq[k+1];
              out_data[k] = out_data[k+1];
            end
            out_cnt--;
            o.timer_stop  = 1'b1;
            o.timer_seq   = r.ack_num;
            o.ack_matched = 1'b1;
          end
        end
      end
      REQ_TIMEOUT: begin
        // timer restarts even if nothing is outstanding under that number
        o.timer_start = 1'b1;
        o.timer_seq   = r.exp_seq;
        hit = -1;
        for (int i = 0; i < out_cnt; i++)
          if (hit < 0 && out_seq[i] == r.exp_seq) hit = i;
        if (hit >= 0) begin
          o.transmit   = 1'b1;
          o.tx_seq     = r.exp_seq;
          o.tx_payload = out_data[hit];
        end
      end
      default: ;
    endcase
    o.window_full = send_blocked();
    return o;
  endfunction

  // mostly well-formed traffic: acks and timeouts aim at outstanding numbers
  function automatic win_req_t rand_req();
    win_req_t r;
    int       pick;
    r.payload = {$urandom, $urandom};
    pick = $urandom_range(0, 15);
    if (pick == 0) r.payload = '0;
    if (pick == 1) r.payload = P_ONES;
    r.ack_num = SEQ_W'($urandom_range(0, 7));
    r.ack_ok  = ($urandom_range(0, 9) != 0);
    r.exp_seq = SEQ_W'($urandom_range(0, 7));
    pick = $urandom_range(0, 99);
    if (pick < 42) begin
      r.kind = REQ_SEND;
    end else if (pick < 77) begin
      r.kind = REQ_ACK;
      if (out_cnt > 0 && $urandom_range(0, 3) != 0)
        r.ack_num = out_seq[$urandom_range(0, out_cnt - 1)];
    end else if (pick < 95) begin
      r.kind = REQ_TIMEOUT;
      if (out_cnt > 0 && $urandom_range(0, 3) != 0)
        r.exp_seq = out_seq[$urandom_range(0, out_cnt - 1)];
    end else begin
      r.kind = REQ_NONE;
    end
    return r;
  endfunction

  task automatic add_row(input req_type_e kind, input logic [PW-1:0] pay,
                         input logic [SEQ_W-1:0] ackn, input logic ok,
                         input logic [SEQ_W-1:0] expn, input bit typed, input win_res_t want);
    dir_row_t row;
    row.req.kind    = kind;
    row.req.payload = pay;
    row.req.ack_num = ackn;
    row.req.ack_ok  = ok;
    row.req.exp_seq = expn;
    row.typed       = typed;
    row.res         = want;
    dir_rows.insert(dir_rows.size(), row);
  endtask

  // called at a falling edge, returns at the falling edge after the item is taken
  task automatic send_req(input win_req_t r, input bit typed, input win_res_t want);
    int       gap;
    win_res_t pred;
    gap = pick_gap();
    if (gap > 0) begin
      req_bus.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_bus.req_type        = r.kind;
    req_bus.payload         = r.payload;
    req_bus.ack_number      = r.ack_num;
    req_bus.ack_checksum_ok = r.ack_ok;
    req_bus.expired_seq     = r.exp_seq;
    req_bus.valid           = 1'b1;
    do @(posedge clk_i); while (req_bus.ready !== 1'b1);
    pred = window_step(r);
    if (typed) pred = want;
    tx_expect_q.insert(tx_expect_q.size(), pred);
    n_items++;
    if (pred.accepted) n_taken++;
    if (r.kind == REQ_SEND && !pred.accepted) n_refused++;
    if (pred.ack_matched) n_matched++;
    if (r.kind == REQ_TIMEOUT && pred.transmit) n_retx++;
    @(negedge clk_i);
  endtask

  task automatic drain();
    req_bus.valid = 1'b0;
    while (tx_expect_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic apb_read(output logic [DATA_W-1:0] d);
    psel    = 1'b1;
    pwrite  = 1'b0;
    penable = 1'b0;
    paddr   = ADDR_WINDOW;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    d = prdata;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  task automatic write_window(input logic [WIN_W-1:0] w);
    logic [DATA_W-1:0] rd;
    psel    = 1'b1;
    pwrite  = 1'b1;
    penable = 1'b0;
    paddr   = ADDR_WINDOW;
    // junk in the upper bits must be dropped
    pwdata  = $urandom;
    pwdata[WIN_W-1:0] = w;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    win_reg = w;
    apb_read(rd);
    if (rd[WIN_W-1:0] !== w) begin
      errors++;
      if (shown < MAX_SHOWN)
        $display("window readback: expected %0d, got %0d", w, rd[WIN_W-1:0]);
      shown++;
    end
  endtask

  initial begin
    res_bus.ready = 1'b0;
    rx_stall      = 0;
    forever begin
      @(negedge clk_i);
      if (rx_stall > 0) begin
        res_bus.ready = 1'b0;
        rx_stall--;
      end else begin
        res_bus.ready = 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    win_res_t got;
    win_res_t want;
    if (rst_ni && res_bus.valid === 1'b1 && res_bus.ready === 1'b1) begin
      got.accepted    = res_bus.accepted;
      got.transmit    = res_bus.transmit;
      got.tx_seq      = res_bus.tx_seq;
      got.tx_payload  = res_bus.tx_payload;
      got.timer_start = res_bus.timer_start;
      got.timer_stop  = res_bus.timer_stop;
      got.timer_seq   = res_bus.timer_seq;
      got.ack_matched = res_bus.ack_matched;
      got.window_full = res_bus.window_full;
      if (tx_expect_q.size() == 0) begin
        errors++;
        if (shown < MAX_SHOWN)
          $display("result item %0d arrived with nothing expected", n_results);
        shown++;
      end else begin
        want = tx_expect_q.pop_front();
        if (got !== want) begin
          errors++;
          if (shown < MAX_SHOWN) begin
            $display("result %0d mismatch (acc tx seq payload start stop tseq match full)",
                     n_results);
            $display("  exp %b %b %0d %h %b %b %0d %b %b", want.accepted, want.transmit,
                     want.tx_seq, want.tx_payload, want.timer_start, want.timer_stop,
                     want.timer_seq, want.ack_matched, want.window_full);
            $display("  got %b %b %0d %h %b %b %0d %b %b", got.accepted, got.transmit,
                     got.tx_seq, got.tx_payload, got.timer_start, got.timer_stop,
                     got.timer_seq, got.ack_matched, got.window_full);
          end
          shown++;
        end
      end
      n_results++;
      rx_stall = pick_gap();
    end
  end

  initial begin
    win_res_t          nil_res;
    win_res_t          full_res;
    logic [DATA_W-1:0] rd;
    rst_ni                  = 1'b0;
    psel                    = 1'b0;
    penable                 = 1'b0;
    pwrite                  = 1'b0;
    paddr                   = '0;
    pwdata                  = '0;
    req_bus.valid           = 1'b0;
    req_bus.req_type        = REQ_NONE;
    req_bus.payload         = '0;
    req_bus.ack_number      = '0;
    req_bus.ack_checksum_ok = 1'b0;
    req_bus.expired_seq     = '0;
    idle_on  = 1'b0;
    win_reg  = WINDOW_RESET;
    nxt_seq  = '0;
    out_cnt  = 0;
    full     = 1'b0;
    for (int i = 0; i < MAXW; i++) begin
      out_seq[i]  = '0;
      out_data[i] = '0;
    end
    nil_res  = mk_res(0, 0, 0, '0, 0, 0, 0, 0, 0);
    full_res = mk_res(0, 0, 0, '0, 0, 0, 0, 0, 1);

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    apb_read(rd);
    if (rd[WIN_W-1:0] !== WINDOW_RESET) begin
      errors++;
      if (shown < MAX_SHOWN) $display("window after reset: got %0d", rd[WIN_W-1:0]);
      shown++;
    end

    // empty queue, then fill window of four, then refusals and ack corner cases
    add_row(REQ_ACK,     '0,     3'd0, 1'b1, 3'd0, 1, nil_res);
    add_row(REQ_TIMEOUT, '0,     3'd0, 1'b0, 3'd5, 1, mk_res(0, 0, 0, '0, 1, 0, 5, 0, 0));
    add_row(REQ_NONE,    P_ONES, 3'd7, 1'b1, 3'd7, 1, nil_res);
    add_row(REQ_SEND,    '0,     3'd0, 1'b0, 3'd0, 1, mk_res(1, 1, 0, '0, 1, 0, 0, 0, 0));
    add_row(REQ_SEND,    P_ONES, 3'd7, 1'b1, 3'd7, 1,
            mk_res(1, 1, 1, P_ONES, 1, 0, 1, 0, 0));
    add_row(REQ_SEND,    P_A5,   3'd0, 1'b0, 3'd0, 1, mk_res(1, 1, 2, P_A5, 1, 0, 2, 0, 0));
    add_row(REQ_SEND,    P_5A,   3'd0, 1'b0, 3'd0, 1, mk_res(1, 1, 3, P_5A, 1, 0, 3, 0, 1));
    add_row(REQ_SEND,    64'h0123_4567_89AB_CDEF, 3'd0, 1'b0, 3'd0, 1, full_res);
    add_row(REQ_ACK,     '0,     3'd1, 1'b0, 3'd0, 1, full_res);
    add_row(REQ_ACK,     '0,     3'd6, 1'b1, 3'd0, 1, full_res);
    add_row(REQ_ACK,     '0,     3'd2, 1'b1, 3'd0, 1, mk_res(0, 0, 0, '0, 0, 1, 2, 1, 1));
    add_row(REQ_ACK,     '0,     3'd2, 1'b1, 3'd0, 1, full_res);
    add_row(REQ_TIMEOUT, '0,     3'd0, 1'b0, 3'd1, 1,
            mk_res(0, 1, 1, P_ONES, 1, 0, 1, 0, 1));
    add_row(REQ_TIMEOUT, '0,     3'd0, 1'b0, 3'd2, 1, mk_res(0, 0, 0, '0, 1, 0, 2, 0, 1));
    add_row(REQ_ACK,     '0,     3'd0, 1'b1, 3'd0, 1, mk_res(0, 0, 0, '0, 0, 1, 0, 1, 0));
    add_row(REQ_SEND,    64'hC3C3_3C3C_0F0F_F0F0, 3'd0, 1'b0, 3'd0, 0, nil_res);
    add_row(REQ_ACK,     '0,     3'd7, 1'b1, 3'd0, 0, nil_res);
    add_row(REQ_ACK,     '0,     3'd1, 1'b1, 3'd0, 0, nil_res);
    add_row(REQ_TIMEOUT, '0,     3'd0, 1'b0, 3'd7, 0, nil_res);
    add_row(REQ_ACK,     '0,     3'd3, 1'b1, 3'd0, 0, nil_res);
    add_row(REQ_ACK,     '0,     3'd4, 1'b1, 3'd0, 0, nil_res);
    add_row(REQ_SEND,    P_ONES, 3'd0, 1'b0, 3'd0, 0, nil_res);
    add_row(REQ_SEND,    '0,     3'd0, 1'b0, 3'd0, 0, nil_res);
    add_row(REQ_TIMEOUT, '0,     3'd0, 1'b0, 3'd6, 0, nil_res);

    foreach (dir_rows[i]) begin
      idle_on = (i >= 12);
      send_req(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].res);
    end
    drain();

    for (int ph = 0; ph < N_PHASES; ph++) begin
      write_window(WIN_PLAN[ph]);
      idle_on = (ph % 4 != 3);
      for (int n = 0; n < PHASE_LEN; n++) begin
        // hold the sender off until the window has answered everything
        if (n == PHASE_LEN / 2) drain();
        send_req(rand_req(), 0, nil_res);
      end
      drain();
    end

    req_bus.valid = 1'b0;
    while (tx_expect_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    errors += tx_expect_q.size();

    $display("%0d requests over %0d window settings: %0d sends taken, %0d refused",
             n_items, N_PHASES + 1, n_taken, n_refused);
    $display("%0d acks matched, %0d retransmits, %0d results, %0d errors",
             n_matched, n_retx, n_results, errors);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/srs_pkg.sv
sv/srs_req_if.sv
sv/srs_res_if.sv
sv/srs_cell.sv
sv/selective_repeat_sender_window.sv
sv/srs_checker.sv
test/tb_top.sv
